// File: rtl/fbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fbd_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int THRESH_BITS   = 15;
    localparam int GAIN_BITS     = 16;
    localparam int GAIN_FRAC     = 12;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [THRESH_BITS-1:0] THRESH_RESET = '1;
    localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = GAIN_BITS'(1 << GAIN_FRAC);

    // Folded or passed value width: wide enough for the sample and for +/- threshold
    localparam int Y_BITS    = (SAMPLE_BITS > THRESH_BITS + 1) ? SAMPLE_BITS : THRESH_BITS + 1;
    localparam int DIFF_BITS = Y_BITS + 1;
    localparam int MAG_BITS  = Y_BITS;
    // |x - t| rem 4t is worked as ((|x - t| >> 2) rem t, low two bits kept)
    localparam int NUM_BITS        = MAG_BITS - 2;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = (NUM_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int NUM_PAD         = DIV_STAGES * STEPS_PER_STAGE;
    localparam int A_BITS          = THRESH_BITS + 1;
    localparam int PROD_BITS       = Y_BITS + GAIN_BITS + 1;

    localparam logic signed [PROD_BITS-1:0] SAT_HI =
        PROD_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [PROD_BITS-1:0] SAT_LO = -SAT_HI - PROD_BITS'(1);
    localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1 << (GAIN_FRAC - 1));

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_THRESHOLD = CFG_IDX_BITS'(0),
        REG_GAIN      = CFG_IDX_BITS'(1)
    } fbd_reg_idx_t;

    typedef struct packed {
        logic [THRESH_BITS-1:0] thresh;
        logic [GAIN_BITS-1:0]   gain;
    } fbd_cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x;
        logic                          fold;
        logic [1:0]                    low2;
        logic [NUM_PAD-1:0]            num;
        logic [THRESH_BITS-1:0]        rem;
    } fbd_div_t;

endpackage

`default_nettype wire

// File: rtl/fbd_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fbd_in_if import fbd_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// File: rtl/fbd_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fbd_out_if import fbd_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// File: rtl/fbd_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface fbd_cfg_if import fbd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// File: rtl/fbd_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module fbd_cfg_regs import fbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    fbd_cfg_if.sink   cfg,
    output fbd_cfg_t  cfg_o
);

    logic [THRESH_BITS-1:0] thresh_reg;
    logic [GAIN_BITS-1:0]   gain_reg;
    logic [THRESH_BITS-1:0] thresh_next;
    logic [GAIN_BITS-1:0]   gain_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        thresh_next = thresh_reg;
        gain_next   = gain_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_THRESHOLD: thresh_next = cfg.wdata[THRESH_BITS-1:0];
                REG_GAIN:      gain_next   = cfg.wdata[GAIN_BITS-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            gain_reg   <= GAIN_RESET;
        end
        else
        begin
            thresh_reg <= thresh_next;
            gain_reg   <= gain_next;
        end
    end

    // A zero threshold acts as one
    assign cfg_o.thresh = (thresh_reg == '0) ? THRESH_BITS'(1) : thresh_reg;
    assign cfg_o.gain   = gain_reg;

    a_thresh_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_o.thresh != '0)
        else $error("effective threshold is zero");

endmodule

`default_nettype wire

// File: rtl/fbd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fbd_front import fbd_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fbd_cfg_t                      cfg_i,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output fbd_div_t                      out_item
);

    logic                        valid_reg;
    logic                        valid_next;
    fbd_div_t                    item_reg;
    fbd_div_t                    item_next;
    logic signed [DIFF_BITS-1:0] xe;
    logic signed [DIFF_BITS-1:0] te;
    logic signed [DIFF_BITS-1:0] diff;
    logic signed [DIFF_BITS-1:0] diff_abs;
    logic [MAG_BITS-1:0]         mag;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        xe       = DIFF_BITS'(sample_in);
        te       = $signed(DIFF_BITS'(cfg_i.thresh));
        diff     = xe - te;
        diff_abs = diff[DIFF_BITS-1] ? -diff : diff;
        mag      = MAG_BITS'(diff_abs);

        item_next.x    = sample_in;
        item_next.fold = (xe > te) || (xe < -te);
        item_next.low2 = mag[1:0];
        item_next.num  = NUM_PAD'(mag >> 2);
        item_next.rem  = '0;
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// File: rtl/fbd_rem_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module fbd_rem_stage import fbd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  fbd_cfg_t cfg_i,
    input  logic     in_valid,
    output logic     in_ready,
    input  fbd_div_t in_item,
    output logic     out_valid,
    input  logic     out_ready,
    output fbd_div_t out_item
);

    logic                   valid_reg;
    logic                   valid_next;
    fbd_div_t               item_reg;
    fbd_div_t               item_next;

    assign in_ready = !valid_reg || out_ready;

    // Shift-subtract long division steps; the partial remainder stays below t
    always_comb
    begin
        logic [THRESH_BITS:0]   trial;
        logic [THRESH_BITS-1:0] r;
        logic [NUM_PAD-1:0]     n;
        r = in_item.rem;
        n = in_item.num;
        for (int k = 0; k < STEPS_PER_STAGE; k++)
        begin
            trial = {r, n[NUM_PAD-1]};
            if (trial >= {1'b0, cfg_i.thresh})
            begin
                trial = trial - {1'b0, cfg_i.thresh};
            end
            r = trial[THRESH_BITS-1:0];
            n = {n[NUM_PAD-2:0], 1'b0};
        end
        item_next      = in_item;
        item_next.rem  = r;
        item_next.num  = n;
    end

    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    a_fill_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("remainder stage became valid without taking an item");

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("remainder stage dropped or changed a blocked item");

endmodule

`default_nettype wire

// File: rtl/fbd_scale.sv
`timescale 1ns / 1ps
`default_nettype none

module fbd_scale import fbd_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fbd_cfg_t                      cfg_i,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fbd_div_t                      in_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample_out
);

    localparam int NSTG = 4;

    logic [NSTG-1:0] valid_reg;
    logic [NSTG-1:0] valid_next;
    logic [NSTG-1:0] rdy;

    // Stage 1: |r - 2t|
    logic [A_BITS-1:0]               a_reg;
    logic signed [SAMPLE_BITS-1:0]   x1_reg;
    logic                            fold1_reg;
    logic [THRESH_BITS+1:0]          r4;
    logic signed [THRESH_BITS+2:0]   diff1;
    logic [A_BITS-1:0]               a_next;
    // Stage 2: fold or pass
    logic signed [Y_BITS-1:0]        y_reg;
    logic signed [THRESH_BITS+1:0]   ym;
    logic signed [Y_BITS-1:0]        y_next;
    // Stage 3: gain product
    logic signed [PROD_BITS-1:0]     p_reg;
    logic signed [PROD_BITS-1:0]     p_next;
    // Stage 4: round and saturate
    logic signed [SAMPLE_BITS-1:0]   s_reg;
    logic signed [PROD_BITS-1:0]     rnd;
    logic signed [PROD_BITS-1:0]     q;
    logic signed [SAMPLE_BITS-1:0]   s_next;

    always_comb
    begin
        rdy[NSTG-1] = !valid_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];

    always_comb
    begin
        valid_next[0] = rdy[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NSTG; i++)
        begin
            valid_next[i] = rdy[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        r4     = {in_item.rem, in_item.low2};
        diff1  = $signed({1'b0, r4}) - $signed({2'b00, cfg_i.thresh, 1'b0});
        a_next = A_BITS'(diff1[THRESH_BITS+2] ? -diff1 : diff1);
    end

    always_comb
    begin
        ym     = $signed({1'b0, a_reg}) - $signed({2'b00, cfg_i.thresh});
        y_next = fold1_reg ? Y_BITS'(ym) : Y_BITS'(x1_reg);
    end

    assign p_next = PROD_BITS'(y_reg) * PROD_BITS'($signed({1'b0, cfg_i.gain}));

    always_comb
    begin
        rnd = p_reg + ROUND_HALF;
        q   = rnd >>> GAIN_FRAC;
        if (q > SAT_HI)
        begin
            s_next = SAMPLE_BITS'(SAT_HI);
        end
        else if (q < SAT_LO)
        begin
            s_next = SAMPLE_BITS'(SAT_LO);
        end
        else
        begin
            s_next = SAMPLE_BITS'(q);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            a_reg     <= a_next;
            x1_reg    <= in_item.x;
            fold1_reg <= in_item.fold;
        end
        if (rdy[1] && valid_reg[0])
        begin
            y_reg <= y_next;
        end
        if (rdy[2] && valid_reg[1])
        begin
            p_reg <= p_next;
        end
        if (rdy[3] && valid_reg[2])
        begin
            s_reg <= s_next;
        end
    end

    assign out_valid  = valid_reg[NSTG-1];
    assign sample_out = s_reg;

    a_empty_tail_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("scale pipeline stalls with an empty output stage");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted item missing from first scale stage");

endmodule

`default_nettype wire

// File: rtl/foldback_distortion_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake      Payload
// din      in   valid / ready  sample_in  (signed, SAMPLE_BITS)
// dout     out  valid / ready  sample_out (signed, SAMPLE_BITS, saturated)
// cfg      in   valid / ready  index (0 threshold, 1 gain), wdata
//
// One item per cycle sustained while dout is ready; the path is the front register,
// DIV_STAGES remainder stages of two shift-subtract steps each, and the scale stages.
// Each stage holds its item while the next one is full and stalled, and an empty stage
// takes a new item even while dout is stalled, so bubbles close up.
// rst_n clears all valid bits and loads threshold 32767 and unity gain. cfg is always
// ready; the user must change registers only between bursts of items (unenforced).

module foldback_distortion_core import fbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    fbd_in_if.sink     din,
    fbd_out_if.source  dout,
    fbd_cfg_if.sink    cfg
);

    fbd_cfg_t          cfg_w;
    logic [DIV_STAGES:0] div_valid;
    logic [DIV_STAGES:0] div_ready;
    fbd_div_t          div_item [DIV_STAGES+1];

    fbd_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_o (cfg_w)
    );

    fbd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_i     (cfg_w),
        .in_valid  (din.valid),
        .in_ready  (din.ready),
        .sample_in (din.sample_in),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_item  (div_item[0])
    );

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_rem
        fbd_rem_stage u_rem (
            .clk       (clk),
            .rst_n     (rst_n),
            .cfg_i     (cfg_w),
            .in_valid  (div_valid[i]),
            .in_ready  (div_ready[i]),
            .in_item   (div_item[i]),
            .out_valid (div_valid[i+1]),
            .out_ready (div_ready[i+1]),
            .out_item  (div_item[i+1])
        );
    end

    fbd_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_i      (cfg_w),
        .in_valid   (div_valid[DIV_STAGES]),
        .in_ready   (div_ready[DIV_STAGES]),
        .in_item    (div_item[DIV_STAGES]),
        .out_valid  (dout.valid),
        .out_ready  (dout.ready),
        .sample_out (dout.sample_out)
    );

endmodule

`default_nettype wire

// File: test/foldback_checker.sv
`timescale 1ns / 1ps

module foldback_checker import fbd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    fbd_in_if     din,
    fbd_out_if    dout,
    fbd_cfg_if    cfg,
    output int    fail_count,
    output int    outstanding
);

    logic [THRESH_BITS-1:0]        thresh_q;
    logic [GAIN_BITS-1:0]          gain_q;
    logic signed [SAMPLE_BITS-1:0] expected_samples[$];

    // Fold the sample into [-t, t] when it lies outside, then scale, round and clamp
    function automatic logic signed [SAMPLE_BITS-1:0] fold_and_scale(
        input logic signed [SAMPLE_BITS-1:0] x,
        input logic [THRESH_BITS-1:0]        thr,
        input logic [GAIN_BITS-1:0]          g
    );
        longint xs;
        longint t;
        longint gg;
        longint y;
        longint r;
        longint p;
        longint hi;
        longint lo;
        xs = x;
        t  = thr;
        gg = g;
        if (t < 1)
            t = 1;
        y = xs;
        if (xs > t || xs < -t)
        begin
            r = (xs - t) % (4 * t);
            if (r < 0)
                r = -r;
            y = r - 2 * t;
            if (y < 0)
                y = -y;
            y = y - t;
        end
        p  = (y * gg + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
        hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        if (p > hi)
            p = hi;
        if (p < lo)
            p = lo;
        return p[SAMPLE_BITS-1:0];
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic signed [SAMPLE_BITS-1:0] want,
                                   input logic signed [SAMPLE_BITS-1:0] got);
        $display("ERROR t=%0t %s: expected %0d got %0d", $realtime, what, want, got);
        fail_count = fail_count + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_q <= THRESH_RESET;
            gain_q   <= GAIN_RESET;
            expected_samples.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_THRESHOLD)
                    thresh_q <= cfg.wdata[THRESH_BITS-1:0];
                else if (cfg.index == REG_GAIN)
                    gain_q <= cfg.wdata[GAIN_BITS-1:0];
            end
            if (din.valid && din.ready)
                expected_samples.push_back(fold_and_scale(din.sample_in, thresh_q, gain_q));
            if (dout.valid && dout.ready)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch("unexpected sample_out", 'x, dout.sample_out);
                else if (dout.sample_out !== expected_samples[0])
                begin
                    report_mismatch("sample_out", expected_samples[0], dout.sample_out);
                    void'(expected_samples.pop_front());
                end
                else
                    void'(expected_samples.pop_front());
            end
            outstanding <= expected_samples.size();
        end
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

module tb import fbd_pkg::*;;

    localparam int FOLD_LATENCY = 1 + DIV_STAGES + 4;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 112;
    localparam logic [CFG_IDX_BITS-1:0] REG_NONE = CFG_IDX_BITS'(2);

    logic clk;
    logic rst_n;
    int   fail_count;
    int   outstanding;
    bit   src_no_idle;
    bit   snk_no_idle;
    int   snk_items;
    logic [THRESH_BITS-1:0] cur_thresh;

    fbd_in_if  din_ch ();
    fbd_out_if dout_ch ();
    fbd_cfg_if cfg_ch ();

    foldback_distortion_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_ch),
        .dout  (dout_ch),
        .cfg   (cfg_ch)
    );

    foldback_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .din         (din_ch),
        .dout        (dout_ch),
        .cfg         (cfg_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial
    begin
        #1000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int draw_gap(input bit no_idle);
        if (no_idle)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // Hold valid high from the previous item when there is no gap
    task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] x);
        int gap;
        gap = draw_gap(src_no_idle);
        if (gap > 0)
        begin
            din_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        din_ch.valid     <= 1'b1;
        din_ch.sample_in <= x;
        do
            @(posedge clk);
        while (!din_ch.ready);
    endtask

    task automatic wait_drained();
        din_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (FOLD_LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_THRESHOLD)
            cur_thresh = data[THRESH_BITS-1:0];
    endtask

    // Bias samples toward the fold edges and their periodic images
    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
        input logic [THRESH_BITS-1:0] thr
    );
        int t;
        int v;
        int k;
        t = (thr == 0) ? 1 : int'(thr);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'($urandom_range(0, 65535)) - 32768;
            4, 5, 6:    v = t + int'($urandom_range(0, 8)) - 4;
            7, 8:
            begin
                k = $urandom_range(1, 8);
                v = k * t + int'($urandom_range(0, 4)) - 2;
            end
            default:    v = ($urandom_range(0, 1) == 1) ? 32767 : 32766;
        endcase
        if ($urandom_range(0, 1) == 1)
            v = -v;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_thresh();
        logic [CFG_DATA_BITS-1:0] d;
        case ($urandom_range(0, 7))
            0:       d = 16'd0;
            1:       d = 16'd1;
            2:       d = 16'd2;
            3:       d = 16'd32767;
            4:       d = 16'd16384;
            5:       d = 16'($urandom_range(1, 300));
            default: d = 16'($urandom_range(1, 32767));
        endcase
        // bit 15 is outside the register and must be dropped
        d[CFG_DATA_BITS-1] = 1'($urandom_range(0, 1));
        return d;
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd65535;
            2:       return 16'd4096;
            3:       return 16'($urandom_range(0, 8192));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Sink: per-item stall, with stretches of no stall
    initial
    begin
        int stall;
        dout_ch.ready <= 1'b0;
        snk_items   = 0;
        snk_no_idle = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_gap(snk_no_idle);
            if (stall > 0)
            begin
                dout_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            dout_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!dout_ch.valid);
            snk_items = snk_items + 1;
            if (snk_items % 64 == 0)
                snk_no_idle = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        din_ch.valid     <= 1'b0;
        din_ch.sample_in <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= '0;
        cfg_ch.wdata     <= '0;
        rst_n            <= 1'b0;
        src_no_idle       = 1'b0;
        cur_thresh        = THRESH_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: wide threshold, unity gain; the most negative sample still folds
        push_sample(16'sd32767);
        push_sample(-16'sd32768);
        push_sample(16'sd0);
        push_sample(16'sd1);
        push_sample(-16'sd1);

        // Zero threshold acts as one; full gain drives saturation
        write_reg(REG_THRESHOLD, 16'd0);
        write_reg(REG_GAIN, 16'd65535);
        push_sample(16'sd1);
        push_sample(-16'sd1);
        push_sample(16'sd2);
        push_sample(-16'sd2);
        push_sample(16'sd32767);
        push_sample(-16'sd32768);

        // Samples at, just past and far past the threshold
        write_reg(REG_THRESHOLD, 16'd100);
        write_reg(REG_GAIN, 16'd4096);
        write_reg(REG_NONE, 16'd7);
        push_sample(16'sd100);
        push_sample(-16'sd100);
        push_sample(16'sd101);
        push_sample(-16'sd101);
        push_sample(16'sd300);
        push_sample(-16'sd300);
        push_sample(16'sd500);

        // Half gain: ties round toward plus infinity
        write_reg(REG_THRESHOLD, 16'hFFFF);
        write_reg(REG_GAIN, 16'd2048);
        push_sample(16'sd1);
        push_sample(-16'sd1);
        push_sample(16'sd3);
        push_sample(-16'sd3);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_reg(REG_THRESHOLD, pick_thresh());
            write_reg(REG_GAIN, pick_gain());
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_BITS'($urandom_range(2, 255)),
                          CFG_DATA_BITS'($urandom_range(0, 65535)));
            src_no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                push_sample(pick_sample(cur_thresh));
                if (i == PHASE_ITEMS / 2 && (ph == 0 || $urandom_range(0, 2) == 0))
                begin
                    // let the pipeline empty before going on
                    din_ch.valid <= 1'b0;
                    @(posedge clk);
                    wait (outstanding == 0);
                end
                if (i % 40 == 39)
                    src_no_idle = ($urandom_range(0, 3) == 0);
            end
        end

        // A last pass at both threshold extremes
        write_reg(REG_THRESHOLD, 16'd1);
        write_reg(REG_GAIN, 16'd65535);
        for (int i = 0; i < 20; i++)
            push_sample(pick_sample(cur_thresh));
        write_reg(REG_THRESHOLD, 16'd32767);
        write_reg(REG_GAIN, 16'd0);
        for (int i = 0; i < 20; i++)
            push_sample(pick_sample(cur_thresh));

        din_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (4 * FOLD_LATENCY) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
rtl/fbd_pkg.sv
rtl/fbd_in_if.sv
rtl/fbd_out_if.sv
rtl/fbd_cfg_if.sv
rtl/fbd_cfg_regs.sv
rtl/fbd_front.sv
rtl/fbd_rem_stage.sv
rtl/fbd_scale.sv
rtl/foldback_distortion_core.sv
test/foldback_checker.sv
test/tb.sv
